@@ design/alist_pkg.sv @@
// Shared types and constants for the array list engine.
// Used by the datapath, the controller and the top level.
package alist_pkg;

  // Default list capacity and the most search hits reported per request
  localparam int ALIST_DEPTH = 16;
  localparam int RESULT_CAP  = 16;

  // Operation codes
  typedef enum logic [2:0] {
    FN_HEAD   = 3'd0,
    FN_ORD    = 3'd1,
    FN_POS    = 3'd2,
    FN_REMOVE = 3'd3,
    FN_SEARCH = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } status_t;

  // Request and result payloads
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [4:0]         position;
  } alist_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] index;
    logic [4:0] removed;
    logic [4:0] entry_count;
    logic       last;
  } alist_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    start;
    logic    ptr_init_count;
    logic    ptr_init_zero;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    j_inc;
    logic    hits_inc;
    logic    rd_en;
    logic    rd_back;
    logic    wr_en;
    logic    wr_value;
    logic    wr_at_j;
    logic    count_inc;
    logic    count_from_j;
    logic    pend_load;
    logic    out_load;
    status_t out_status;
    logic    out_last;
    logic    out_pend;
    logic    out_hits;
  } alist_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       empty;
    logic       pos_bad;
    logic       ptr_zero;
    logic       ptr_at_pos;
    logic       ptr_end;
    logic       rd_gt;
    logic       rd_eq;
    logic       hits_zero;
    logic       hits_cap;
    logic       pend_vld;
    logic       out_free;
  } alist_sts_t;

endpackage

@@ design/alist_chan_if.sv @@
// Valid/ready channel carrying one request or result payload.
// Payload type is a parameter; the engine uses the structs of alist_pkg.
interface alist_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/alist_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/alist_dp.sv @@
// Datapath of the array list engine: entry RAM, count, walk pointers,
// match counter and the result register. Depends on alist_pkg and alist_ram.
module alist_dp #(
  parameter int DEPTH = alist_pkg::ALIST_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  alist_pkg::alist_cmd_t  cmd,
  input  alist_pkg::alist_in_t   in_req,
  output alist_pkg::alist_sts_t  sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output alist_pkg::alist_out_t  out_rsp
);
  import alist_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > 5) ? CW : 5;

  logic [2:0]         func_r;
  logic signed [31:0] value_r;
  logic [4:0]         pos_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      ptr_r;
  logic [CW-1:0]      j_r;
  logic [WW-1:0]      hits_r;
  logic [CW-1:0]      pend_r;
  logic               pend_vld_r;
  logic               out_valid_r;
  alist_out_t         out_r;

  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      wr_idx;
  logic [31:0]        wr_data;
  logic [31:0]        rd_data;
  logic [WW-1:0]      cnt_ext;
  logic [WW-1:0]      pend_ext;
  logic [WW-1:0]      pos_ext;
  logic [WW-1:0]      ptr_ext;

  // Entry store
  assign rd_idx  = cmd.rd_back ? (ptr_r - CW'(1)) : ptr_r;
  assign wr_idx  = cmd.wr_at_j ? j_r : ptr_r;
  assign wr_data = cmd.wr_value ? value_r : rd_data;

  alist_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Request operands
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r  <= in_req.func;
      value_r <= in_req.value;
      pos_r   <= in_req.position;
    end
  end

  // Entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_from_j) begin
      count_nxt = j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Walk pointers and match bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.ptr_init_count) begin
      ptr_r <= count_r;
    end else if (cmd.ptr_init_zero) begin
      ptr_r <= '0;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - CW'(1);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + CW'(1);
    end

    if (cmd.ptr_init_zero) begin
      j_r    <= '0;
      hits_r <= '0;
    end else begin
      if (cmd.j_inc) begin
        j_r <= j_r + CW'(1);
      end
      if (cmd.hits_inc) begin
        hits_r <= hits_r + WW'(1);
      end
    end

    if (cmd.pend_load) begin
      pend_r <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.ptr_init_zero) begin
      pend_vld_r <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_vld_r <= 1'b1;
    end
  end

  // Result register
  assign cnt_ext  = WW'(count_nxt);
  assign pend_ext = WW'(pend_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status      <= cmd.out_status;
      out_r.index       <= cmd.out_pend ? pend_ext[3:0] : 4'd0;
      out_r.removed     <= cmd.out_hits ? hits_r[4:0] : 5'd0;
      out_r.entry_count <= cnt_ext[4:0];
      out_r.last        <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // Status back to the controller
  assign pos_ext = WW'(pos_r);
  assign ptr_ext = WW'(ptr_r);

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.full       = (count_r == CW'(DEPTH));
    sts.empty      = (count_r == '0);
    sts.pos_bad    = (pos_ext > WW'(count_r));
    sts.ptr_zero   = (ptr_r == '0);
    sts.ptr_at_pos = (ptr_ext == pos_ext);
    sts.ptr_end    = (ptr_r == count_r);
    sts.rd_gt      = ($signed(rd_data) > value_r);
    sts.rd_eq      = ($signed(rd_data) == value_r);
    sts.hits_zero  = (hits_r == '0);
    sts.hits_cap   = (hits_r == WW'(RESULT_CAP));
    sts.pend_vld   = pend_vld_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

@@ design/alist_ctrl.sv @@
// Controller of the array list engine: sequences dispatch, the shift walk for
// inserts and the scan for remove and search. Depends on alist_pkg.
module alist_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  alist_pkg::alist_sts_t sts,
  output alist_pkg::alist_cmd_t cmd
);
  import alist_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DISP    = 6'b000010,
    S_INS_RD  = 6'b000100,
    S_INS_EV  = 6'b001000,
    S_SCAN_RD = 6'b010000,
    S_SCAN_EV = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic is_ins, is_scan, is_remove, is_search, ins_stop, scan_done;

  assign is_remove = (sts.func == FN_REMOVE);
  assign is_search = (sts.func == FN_SEARCH);
  assign is_ins    = (sts.func == FN_HEAD) || (sts.func == FN_ORD) || (sts.func == FN_POS);
  assign is_scan   = is_remove || is_search;
  // Shift walk ends at the target slot
  assign ins_stop  = (sts.func == FN_POS) ? sts.ptr_at_pos : sts.ptr_zero;
  assign scan_done = sts.ptr_end || (is_search && sts.hits_cap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.out_status = ST_OK;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DISP;
        end
      end

      // Reject cases and unused codes answer once the result register is free, otherwise start a walk
      S_DISP: begin
        priority if (is_ins && !sts.full && !((sts.func == FN_POS) && sts.pos_bad)) begin
          cmd.ptr_init_count = 1'b1;
          state_nxt          = S_INS_RD;
        end else if (is_scan && !sts.empty) begin
          cmd.ptr_init_zero = 1'b1;
          state_nxt         = S_SCAN_RD;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          if (is_ins) begin
            cmd.out_status = sts.full ? ST_FULL : ST_BADPOS;
          end else if (is_scan) begin
            cmd.out_status = ST_EMPTY;
          end else begin
            cmd.out_status = ST_OK;
          end
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DISP;
        end
      end

      // Fetch the entry in front of the gap, or drop the value in
      S_INS_RD: begin
        if (ins_stop) begin
          if (sts.out_free) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_value  = 1'b1;
            cmd.count_inc = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_last  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_back = 1'b1;
          state_nxt   = S_INS_EV;
        end
      end

      // Move the fetched entry back one place, unless ordered insert stops here
      S_INS_EV: begin
        if ((sts.func == FN_ORD) && !sts.rd_gt) begin
          if (sts.out_free) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_value  = 1'b1;
            cmd.count_inc = 1'b1;
            cmd.out_load  = 1'b1;
            cmd.out_last  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.ptr_dec = 1'b1;
          state_nxt   = S_INS_RD;
        end
      end

      // Fetch the next entry or close the scan
      S_SCAN_RD: begin
        if (scan_done) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            if (sts.hits_zero) begin
              cmd.out_status = ST_NOTFOUND;
            end else begin
              cmd.out_status   = ST_OK;
              cmd.out_hits     = is_remove;
              cmd.count_from_j = is_remove;
              cmd.out_pend     = is_search;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SCAN_EV;
        end
      end

      // Compact on remove; on search hold each hit until the next one shows up
      S_SCAN_EV: begin
        if (is_remove) begin
          if (sts.rd_eq) begin
            cmd.hits_inc = 1'b1;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wr_at_j = 1'b1;
            cmd.j_inc   = 1'b1;
          end
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end else if (!(sts.rd_eq && sts.pend_vld && !sts.out_free)) begin
          if (sts.rd_eq) begin
            if (sts.pend_vld) begin
              cmd.out_load = 1'b1;
              cmd.out_pend = 1'b1;
            end
            cmd.pend_load = 1'b1;
            cmd.hits_inc  = 1'b1;
          end
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/array_list_engine_core.sv @@
// Array list engine top level: compact list of signed 32-bit values.
// Depends on alist_pkg, alist_chan_if, alist_ctrl, alist_dp and alist_ram.
//
// Usage:
//   in_ch  (sink)   request: func, value, position. Accepted when valid and ready.
//   out_ch (source) results: status, index, removed, entry_count, last.
//   Every request gives at least one result; the final one has last set.
//   Search gives one result per hit (lowest index first, at most 16).
// Sequencing (one request at a time):
//   Rejects and unused codes: the result is loaded from the dispatch state.
//   Inserts move entries back one place at a time from the end; an ordered
//   insert stops at the first entry not greater than its value. Remove and
//   search visit the entries in turn through the single read port of the
//   entry RAM (address state, then compare/write state); ready returns when
//   the walk is done.
// Reset: synchronous active-low rst_n empties the list and the result register.
//   Entry RAM contents are not cleared; only entries below the count are read.
// Stalls: a result waits in the output register; a new request is still taken
//   while it waits. The walk pauses only when a further result must be loaded.
module array_list_engine_core #(
  parameter int DEPTH = alist_pkg::ALIST_DEPTH
) (
  input logic         clk,
  input logic         rst_n,
  alist_chan_if.sink   in_ch,
  alist_chan_if.source out_ch
);
  import alist_pkg::*;

  alist_cmd_t cmd;
  alist_sts_t sts;
  alist_in_t  in_req;
  alist_out_t out_rsp;
  logic       in_ready;
  logic       out_valid;

  assign in_req = in_ch.payload;

  alist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_rsp   (out_rsp)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_rsp;

  // One request in flight: ready drops right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in progress");

  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");

  // Inserts never grow a full list
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_inc |-> !sts.full)
    else $error("count grown past capacity");

  // Search hit count stays within the result cap
  a_hit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hits_inc && (sts.func == FN_SEARCH)) |-> !sts.hits_cap)
    else $error("search hits beyond cap");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for array_list_engine_core: directed list cases, then random traffic.
// Depends on alist_pkg, alist_chan_if and the engine RTL; expected results come from a
// behavioral list model kept in this file.
module tb_top;
  import alist_pkg::*;

  localparam int         LIST_DEPTH   = ALIST_DEPTH;
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;
  localparam int         VAL_MIN      = int'(32'h8000_0000);
  localparam int         VAL_MAX      = int'(32'h7fff_ffff);
  localparam int         RANDOM_ITEMS = 450;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         MAX_PRINTS   = 40;

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  alist_chan_if #(.payload_t(alist_in_t))  req_ch ();
  alist_chan_if #(.payload_t(alist_out_t)) res_ch ();

  array_list_engine_core #(.DEPTH(LIST_DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch.sink),
    .out_ch(res_ch.source)
  );

  // List model and pending results
  int         list_vals [LIST_DEPTH];
  int         list_count = 0;
  alist_out_t expected_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit src_no_idle    = 1'b0;
  bit sink_no_stall  = 1'b0;

  // Apply one request to the list model and queue the results it should produce
  function automatic void predict_list_op(input alist_in_t req);
    alist_out_t res;
    int v, slot, kept, hits, n, i;
    v = req.value;
    res = '0;
    res.status = ST_OK;
    res.last = 1'b1;
    case (req.func)
      FN_HEAD, FN_ORD, FN_POS: begin
        if (list_count == LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (req.func == FN_POS && req.position > list_count) begin
          res.status = ST_BADPOS;
        end else begin
          if (req.func == FN_HEAD) begin
            slot = 0;
          end else if (req.func == FN_ORD) begin
            // only strictly greater entries move back
            slot = list_count;
            while (slot > 0 && list_vals[slot - 1] > v) slot--;
          end else begin
            slot = req.position;
          end
          for (i = list_count; i > slot; i--) list_vals[i] = list_vals[i - 1];
          list_vals[slot] = v;
          list_count++;
        end
      end
      FN_REMOVE: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          kept = 0;
          hits = 0;
          for (i = 0; i < list_count; i++) begin
            if (list_vals[i] == v) begin
              hits++;
            end else begin
              list_vals[kept] = list_vals[i];
              kept++;
            end
          end
          if (hits == 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            list_count = kept;
            res.removed = 5'(hits);
          end
        end
      end
      FN_SEARCH: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hits = 0;
          for (i = 0; i < list_count; i++) if (list_vals[i] == v) hits++;
          if (hits > RESULT_CAP) hits = RESULT_CAP;
          if (hits == 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            // one result per hit, lowest index first
            n = 0;
            res.entry_count = 5'(list_count);
            for (i = 0; i < list_count && n < hits; i++) begin
              if (list_vals[i] == v) begin
                res.index = 4'(i);
                res.last = (n == hits - 1);
                expected_results.push_back(res);
                n++;
              end
            end
            return;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(list_count);
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[cycle %0d] mismatch: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // Present one request after a random gap, hold it until taken, then predict
  task automatic send_request(input logic [2:0] func, input int value,
                              input logic [4:0] position);
    alist_in_t req;
    int gap;
    req.func = func;
    req.value = value;
    req.position = position;
    gap = src_no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= req;
    do @(posedge clk); while (!req_ch.ready);
    predict_list_op(req);
  endtask

  // Hold off new requests until every pending result has arrived
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Fill with one value, hit the full list, search with the most hits, remove all
  task automatic test_capacity();
    int k;
    for (k = 0; k < LIST_DEPTH; k++) begin
      case (k % 3)
        0:       send_request(FN_HEAD, VAL_MIN, 5'($urandom_range(0, 31)));
        1:       send_request(FN_ORD, VAL_MIN, 5'($urandom_range(0, 31)));
        default: send_request(FN_POS, VAL_MIN, 5'($urandom_range(0, list_count)));
      endcase
    end
    send_request(FN_HEAD, 1, '0);
    send_request(FN_ORD, VAL_MAX, '0);
    send_request(FN_POS, 2, 5'd31);
    send_request(FN_SEARCH, VAL_MIN, '0);
    wait_drained();
    send_request(FN_REMOVE, VAL_MIN, '0);
  endtask

  // Empty list, position past the end, unused operation codes
  task automatic test_empty_cases();
    send_request(FN_REMOVE, 5, '0);
    send_request(FN_SEARCH, 5, '0);
    send_request(FN_POS, 9, 5'd16);
    send_request(FN_SPARE_LO, VAL_MAX, 5'd31);
    send_request(FN_SPARE_HI, VAL_MIN, '0);
  endtask

  // Ordering across the signed extremes, misses and a single hit
  task automatic test_value_extremes();
    send_request(FN_ORD, VAL_MAX, '0);
    send_request(FN_ORD, VAL_MIN, '0);
    send_request(FN_ORD, -1, '0);
    send_request(FN_POS, 0, 5'd1);
    send_request(FN_SEARCH, 12345, '0);
    send_request(FN_REMOVE, 12345, '0);
    send_request(FN_SEARCH, -1, '0);
  endtask

  // Phases of random traffic, each with its own op mix, value pool and idle pattern
  task automatic test_random_traffic(input int n_items);
    int sent, phase_len, mix, pick, k, ins_lim, rem_lim, value;
    int pool [6];
    logic [2:0] func;
    logic [4:0] position;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(10, 40);
      mix = $urandom_range(0, 3);
      case (mix)
        0:       begin ins_lim = 65; rem_lim = 78; end
        1:       begin ins_lim = 30; rem_lim = 75; end
        2:       begin ins_lim = 40; rem_lim = 48; end
        default: begin ins_lim = 80; rem_lim = 88; end
      endcase
      // small pool so that duplicates and hits are common
      for (k = 0; k < 6; k++) begin
        case ($urandom_range(0, 3))
          0:       pool[k] = $urandom;
          1:       pool[k] = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
          default: pool[k] = int'($urandom_range(0, 6)) - 3;
        endcase
      end
      src_no_idle = ($urandom_range(0, 3) == 0);
      sink_no_stall = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) wait_drained();
      for (k = 0; k < phase_len && sent < n_items; k++) begin
        pick = $urandom_range(0, 99);
        value = ($urandom_range(0, 6) == 0) ? int'($urandom) : pool[$urandom_range(0, 5)];
        position = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31)) :
                                                 5'($urandom_range(0, list_count));
        if (pick < 3) begin
          func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        end else if (pick < ins_lim) begin
          func = (mix == 3) ? FN_ORD : 3'($urandom_range(FN_HEAD, FN_POS));
        end else begin
          func = (pick < rem_lim) ? FN_REMOVE : FN_SEARCH;
          if (list_count > 0 && $urandom_range(0, 1))
            value = list_vals[$urandom_range(0, list_count - 1)];
        end
        send_request(func, value, position);
        sent++;
      end
    end
  endtask

  // Result consumer: random stall before each result
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = sink_no_stall ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : result_check
    alist_out_t got, want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = res_ch.payload;
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, status", got.status, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.index !== want.index)
          report_mismatch("index", got.index, want.index);
        if (got.removed !== want.removed)
          report_mismatch("removed", got.removed, want.removed);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** array_list_engine_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_capacity();
    test_empty_cases();
    test_value_extremes();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** array_list_engine_core: PASSED **");
    end else begin
      $display("** array_list_engine_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/alist_pkg.sv
design/alist_chan_if.sv
design/alist_ram.sv
design/alist_dp.sv
design/alist_ctrl.sv
design/array_list_engine_core.sv
tb/tb_top.sv
